// ===== sv/pix_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pix_pkg
// Types and constants shared by the interval sampler modules.
// ----------------------------------------------------------------------------
package pix_pkg;

  localparam int unsigned DataW = 32;

  // Xorshift shift amounts.
  localparam int unsigned ShiftA = 13;
  localparam int unsigned ShiftB = 17;
  localparam int unsigned ShiftC = 5;

  localparam logic [DataW-1:0] GenReset       = 32'd1;
  localparam logic [DataW-1:0] CutoffReset    = 32'hFFFF_FFFF;
  localparam logic [DataW-1:0] TimeStepReset  = 32'd1;

  // Operation codes of an input beat.
  localparam logic OpDraw = 1'b0;
  localparam logic OpLoad = 1'b1;

  // Configuration register indexes.
  localparam logic CfgCutoff   = 1'b0;
  localparam logic CfgTimeStep = 1'b1;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StFirst = 3'b010,
    StRun   = 3'b100
  } state_e;

  // Result of one pass through the shared step unit.
  typedef struct packed {
    logic [DataW-1:0] next_state;
    logic [DataW-1:0] next_interval;
    logic             reject;
  } step_res_t;

endpackage

// ===== sv/pix_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pix_step
// Shared step unit: one xorshift advance, the cutoff compare on the current
// state and the interval accumulate.
// ----------------------------------------------------------------------------
module pix_step (
  input  logic [pix_pkg::DataW-1:0] state_i,
  input  logic [pix_pkg::DataW-1:0] interval_i,
  input  logic [pix_pkg::DataW-1:0] cutoff_i,
  input  logic [pix_pkg::DataW-1:0] time_step_i,
  output pix_pkg::step_res_t        res_o
);

  logic [pix_pkg::DataW-1:0] x1;
  logic [pix_pkg::DataW-1:0] x2;

  assign x1 = state_i ^ (state_i << pix_pkg::ShiftA);
  assign x2 = x1 ^ (x1 >> pix_pkg::ShiftB);

  assign res_o.next_state    = x2 ^ (x2 << pix_pkg::ShiftC);
  assign res_o.next_interval = interval_i + time_step_i;
  assign res_o.reject        = state_i > cutoff_i;

endmodule

// ===== sv/pix_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pix_seq
// Sequencer: holds the generator state, steps it through the shared unit
// until a trial is accepted or the trial limit is hit, and holds the result.
// ----------------------------------------------------------------------------
module pix_seq #(
  parameter longint unsigned MAX_TRIALS = 65536
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      operation_i,
  input  logic [pix_pkg::DataW-1:0] seed_value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [pix_pkg::DataW-1:0] interval_o,
  output logic                      gave_up_o,
  input  logic [pix_pkg::DataW-1:0] cutoff_i,
  input  logic [pix_pkg::DataW-1:0] time_step_i
);

  localparam int unsigned CntW = $clog2(MAX_TRIALS + 64'd1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_TRIALS);

  pix_pkg::state_e            state_q, state_d;
  logic [pix_pkg::DataW-1:0]  gen_q, gen_d;
  logic [pix_pkg::DataW-1:0]  acc_q, acc_d;
  logic [CntW-1:0]            rej_q, rej_d;
  logic                       out_valid_q, out_valid_d;
  logic [pix_pkg::DataW-1:0]  out_int_q, out_int_d;
  logic                       out_gave_q, out_gave_d;
  pix_pkg::step_res_t         res;
  logic                       out_free;

  pix_step u_step (
    .state_i     (gen_q),
    .interval_i  (acc_q),
    .cutoff_i    (cutoff_i),
    .time_step_i (time_step_i),
    .res_o       (res)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    gen_d       = gen_q;
    acc_d       = acc_q;
    rej_d       = rej_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_int_d   = out_int_q;
    out_gave_d  = out_gave_q;
    case (state_q)
      pix_pkg::StIdle: begin
        if (in_valid_i) begin
          if (operation_i == pix_pkg::OpLoad) begin
            gen_d = seed_value_i;
          end else begin
            acc_d   = '0;
            rej_d   = '0;
            state_d = pix_pkg::StFirst;
          end
        end
      end
      pix_pkg::StFirst: begin
        gen_d   = res.next_state;
        state_d = pix_pkg::StRun;
      end
      pix_pkg::StRun: begin
        if (!res.reject || (rej_q == MaxCnt)) begin
          // Finish only once the result register can take the beat.
          if (out_free) begin
            out_valid_d = 1'b1;
            out_int_d   = acc_q;
            out_gave_d  = res.reject;
            state_d     = pix_pkg::StIdle;
          end
        end else begin
          gen_d = res.next_state;
          acc_d = res.next_interval;
          rej_d = rej_q + 1'b1;
        end
      end
      default: begin
        state_d = pix_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pix_pkg::StIdle;
      gen_q       <= pix_pkg::GenReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gen_q       <= gen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    rej_q      <= rej_d;
    out_int_q  <= out_int_d;
    out_gave_q <= out_gave_d;
  end

  assign in_stall_o  = (state_q != pix_pkg::StIdle);
  assign out_valid_o = out_valid_q;
  assign interval_o  = out_int_q;
  assign gave_up_o   = out_gave_q;

endmodule

// ===== sv/poisson_interval_xorshift.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poisson_interval_xorshift
// Geometric inter-event interval sampler on a 32-bit xorshift generator.
// ----------------------------------------------------------------------------
// A load beat replaces the generator state and gives no result. A draw beat
// steps the generator through the single step unit: the beat is taken in the
// idle state, then there is one xorshift step per cycle, for the first trial
// and for each rejected one that is retried (at most MAX_TRIALS); this unit
// sets the rate. Last, the result moves into the output register. The block
// accepts no new beat during a draw. A finished result waits in the output
// register, and a draw that finishes while that register is still held waits
// for it.
// ----------------------------------------------------------------------------
module poisson_interval_xorshift #(
  parameter longint unsigned MAX_TRIALS = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [31:0] seed_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] interval_o,
  output logic        gave_up_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_wdata_i
);

  logic [pix_pkg::DataW-1:0] cutoff_q;
  logic [pix_pkg::DataW-1:0] time_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q    <= pix_pkg::CutoffReset;
      time_step_q <= pix_pkg::TimeStepReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pix_pkg::CfgCutoff:   cutoff_q    <= cfg_wdata_i;
        pix_pkg::CfgTimeStep: time_step_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  pix_seq #(
    .MAX_TRIALS (MAX_TRIALS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .seed_value_i (seed_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .interval_o   (interval_o),
    .gave_up_o    (gave_up_o),
    .cutoff_i     (cutoff_q),
    .time_step_i  (time_step_q)
  );

endmodule
